### rtl/rbd_pkg.sv
// shared types and constants for the ring buffer deque core
// no dependencies; used by ring_buffer_deque_core
package rbd_pkg;

  localparam int ActionWidth = 3;
  localparam int ValueWidth  = 32;
  localparam int CountWidth  = 11;

  localparam logic [ActionWidth-1:0] ACT_NONE       = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_POP_BACK   = 3'd4;

  localparam logic signed [ValueWidth-1:0] NO_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  // result word, first member in the highest bits
  typedef struct packed {
    logic signed [ValueWidth-1:0] back_value;
    logic signed [ValueWidth-1:0] front_value;
    logic                         is_full;
    logic                         is_empty;
    logic [CountWidth-1:0]        entry_count;
    logic                         push_dropped;
    logic                         pop_failed;
    logic signed [ValueWidth-1:0] pop_value;
  } result_t;

endpackage

### rtl/rbd_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ring_buffer_deque_core.sv
// ring buffer deque: circular store in one ram, cached front and back words
// depends on rbd_pkg and rbd_ram
//
// the result is registered at accept; a pop that leaves entries behind goes
// through the fetch state, as the new end word comes from the ram read port
// one word per cycle while out_tready is high; such pops stall input in fetch
// reset clears state, pointers, count and output valid; the store is not cleared
module ring_buffer_deque_core #(
  parameter int CAPACITY = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // action[2:0], push_value[34:3], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // pop_value, pop_failed, push_dropped,
                                   // entry_count, is_empty, is_full,
                                   // front_value, back_value, zero pad
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] LastIdx = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] FullCnt = CW'(CAPACITY);

  rbd_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] fp_r, fp_nxt, bp_r, bp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [rbd_pkg::ValueWidth-1:0] front_val_r, front_val_nxt;
  logic signed [rbd_pkg::ValueWidth-1:0] back_val_r, back_val_nxt;
  logic fetch_front_r, fetch_front_nxt;
  rbd_pkg::result_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [rbd_pkg::ActionWidth-1:0] action;
  logic signed [rbd_pkg::ValueWidth-1:0] push_value;
  logic in_accept;

  logic [PW-1:0] fp_inc, fp_dec, bp_inc, bp_dec, bp_dec2;
  logic is_full_now, is_empty_now;
  logic signed [rbd_pkg::ValueWidth-1:0] popped;
  logic pop_failed, push_dropped, need_fetch;
  logic [CW+10:0] count_ext;

  logic wr_en;
  logic [PW-1:0] wr_addr, rd_addr;
  logic [rbd_pkg::ValueWidth-1:0] rd_data;

  assign action     = in_tdata[2:0];
  assign push_value = in_tdata[34:3];
  assign in_tready  = (state_r == rbd_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;

  assign fp_inc  = (fp_r == LastIdx) ? '0 : fp_r + 1'b1;
  assign fp_dec  = (fp_r == '0) ? LastIdx : fp_r - 1'b1;
  assign bp_inc  = (bp_r == LastIdx) ? '0 : bp_r + 1'b1;
  assign bp_dec  = (bp_r == '0) ? LastIdx : bp_r - 1'b1;
  assign bp_dec2 = (bp_dec == '0) ? LastIdx : bp_dec - 1'b1;

  assign is_full_now  = (count_r == FullCnt);
  assign is_empty_now = (count_r == '0);
  assign count_ext    = (CW + 11)'(count_nxt);

  always_comb begin
    state_nxt       = state_r;
    fp_nxt          = fp_r;
    bp_nxt          = bp_r;
    count_nxt       = count_r;
    front_val_nxt   = front_val_r;
    back_val_nxt    = back_val_r;
    fetch_front_nxt = fetch_front_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    popped          = rbd_pkg::NO_VALUE;
    pop_failed      = 1'b0;
    push_dropped    = 1'b0;
    need_fetch      = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = bp_r;
    rd_addr         = fp_inc;

    if (state_r == rbd_pkg::S_FETCH) begin
      // new end word arrives from the ram
      if (fetch_front_r) begin
        front_val_nxt       = rd_data;
        out_nxt.front_value = rd_data;
      end else begin
        back_val_nxt       = rd_data;
        out_nxt.back_value = rd_data;
      end
      out_valid_nxt = 1'b1;
      state_nxt     = rbd_pkg::S_IDLE;
    end else if (in_accept) begin
      case (action)
        rbd_pkg::ACT_PUSH_FRONT: begin
          if (is_full_now) begin
            push_dropped = 1'b1;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = fp_dec;
            fp_nxt        = fp_dec;
            count_nxt     = count_r + 1'b1;
            front_val_nxt = push_value;
            if (is_empty_now) begin
              back_val_nxt = push_value;
            end
          end
        end
        rbd_pkg::ACT_PUSH_BACK: begin
          if (is_full_now) begin
            push_dropped = 1'b1;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = bp_r;
            bp_nxt       = bp_inc;
            count_nxt    = count_r + 1'b1;
            back_val_nxt = push_value;
            if (is_empty_now) begin
              front_val_nxt = push_value;
            end
          end
        end
        rbd_pkg::ACT_POP_FRONT: begin
          if (is_empty_now) begin
            pop_failed = 1'b1;
          end else begin
            popped          = front_val_r;
            fp_nxt          = fp_inc;
            count_nxt       = count_r - 1'b1;
            rd_addr         = fp_inc;
            fetch_front_nxt = 1'b1;
            need_fetch      = (count_r != CW'(1));
          end
        end
        rbd_pkg::ACT_POP_BACK: begin
          if (is_empty_now) begin
            pop_failed = 1'b1;
          end else begin
            popped          = back_val_r;
            bp_nxt          = bp_dec;
            count_nxt       = count_r - 1'b1;
            rd_addr         = bp_dec2;
            fetch_front_nxt = 1'b0;
            need_fetch      = (count_r != CW'(1));
          end
        end
        default: begin
        end
      endcase

      out_nxt.pop_value    = popped;
      out_nxt.pop_failed   = pop_failed;
      out_nxt.push_dropped = push_dropped;
      out_nxt.entry_count  = count_ext[10:0];
      out_nxt.is_empty     = (count_nxt == '0);
      out_nxt.is_full      = (count_nxt == FullCnt);
      out_nxt.front_value  = (count_nxt == '0) ? rbd_pkg::NO_VALUE : front_val_nxt;
      out_nxt.back_value   = (count_nxt == '0) ? rbd_pkg::NO_VALUE : back_val_nxt;

      if (need_fetch) begin
        state_nxt = rbd_pkg::S_FETCH;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbd_pkg::S_IDLE;
      fp_r        <= '0;
      bp_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      bp_r        <= bp_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    front_val_r   <= front_val_nxt;
    back_val_r    <= back_val_nxt;
    fetch_front_r <= fetch_front_nxt;
    out_r         <= out_nxt;
  end

  rbd_ram #(
    .WIDTH (rbd_pkg::ValueWidth),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("entry count above capacity");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FullCnt) |-> (fp_r == bp_r))
    else $error("pointers disagree with empty or full count");

  a_fetch_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbd_pkg::S_FETCH) |-> !out_valid_r)
    else $error("fetch cycle with output still occupied");

  a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbd_pkg::S_FETCH) |=> (out_valid_r && state_r == rbd_pkg::S_IDLE))
    else $error("fetch did not complete in one cycle");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbd_pkg::S_FETCH) |-> !wr_en)
    else $error("store written during end fetch");

endmodule
